// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL; compiled out under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked at every clock edge, outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition in a cycle implies a consequence in the same cycle.
`define ASSERT_IMPLIES(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(label, prop, msg)
`define ASSERT_IMPLIES(label, cond, conseq, msg)
`endif
`endif

// File: rtl/dbdt_pkg.sv
// Types, codes and helpers for the dual button debounce timer.
`default_nettype none
package dbdt_pkg;

  localparam int INTERVAL_W = 10;
  localparam int PTIME_W    = 16;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 2;

  // Input word modes
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_EDGE  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAIN_LEVEL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_EN    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_LEVEL = 2'd3;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2
  } ev_t;

  typedef struct packed {
    logic               active;
    logic [PTIME_W-1:0] ptime;
    ev_t                ev;
  } sample_t;

  function automatic logic [PTIME_W-1:0] sat_add(input logic [PTIME_W-1:0] a,
                                                 input logic [INTERVAL_W-1:0] b);
    logic [PTIME_W:0] s;
    s = {1'b0, a} + {{(PTIME_W + 1 - INTERVAL_W){1'b0}}, b};
    return s[PTIME_W] ? {PTIME_W{1'b1}} : s[PTIME_W-1:0];
  endfunction

  // One debounce sample of one button.
  function automatic sample_t sample_one(input logic active,
                                         input logic at_level,
                                         input logic [PTIME_W-1:0] ptime,
                                         input logic [INTERVAL_W-1:0] interval);
    sample_t r;
    r.active = active;
    r.ptime  = ptime;
    r.ev     = EV_NONE;
    if (active) begin
      if (at_level) begin
        if (ptime == '0) begin
          r.ptime = sat_add(sat_add(ptime, interval), interval);
          r.ev    = EV_PRESS;
        end else begin
          r.ptime = sat_add(ptime, interval);
        end
      end else begin
        r.active = 1'b0;
        r.ptime  = '0;
        r.ev     = EV_RELEASE;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/dual_button_debounce_timer_unit.sv
// Top level of the dual button debounce timer with press duration.
//
// Usage:
//   Input channel (in_*): one word per millisecond tick, button edge or
//   clear command, taken when in_valid is high and in_stall is low.
//   Result channel (out_*): exactly one result word per input word, in
//   order, taken when out_valid is high and out_stall is low.
//   Config port (cfg_*): cfg_we writes cfg_data into register cfg_index
//   at the clock edge; write only while no word is in flight.
// Path: an accepted word waits in the input register, is processed out of
//   it and lands in the result register once that register can load.
// Throughput: one word per cycle while out_stall is low; the per-word update
//   of timer, flags and press times is one logic level between the registers.
// Stall: while out_stall holds a pending result, one more word can be
//   taken into the input register; after that in_stall rises until the
//   result is taken. State changes only when a word advances or on a cfg write.
// Reset (rst_n low, synchronous): timer stopped, both buttons idle, press
//   times zero, registers at interval 5, main level 0, mirror off, mirror
//   level 1; both registers empty.
`default_nettype none
`include "assert_macros.svh"
module dual_button_debounce_timer_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [1:0]                     in_mode,
  input  wire logic                           in_button_index,
  input  wire logic                           in_main_level,
  input  wire logic                           in_mirror_level,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [1:0]                          out_main_event,
  output logic [1:0]                          out_mirror_event,
  output logic                                out_is_pressed,
  output logic [dbdt_pkg::PTIME_W-1:0]        out_pressed_time,
  input  wire logic                           cfg_we,
  input  wire logic [dbdt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dbdt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dbdt_pkg::*;

  // Configuration registers
  logic [INTERVAL_W-1:0] interval_r;
  logic                  main_lvl_cfg_r;
  logic                  mirror_en_r;
  logic                  mirror_lvl_cfg_r;

  // Block state
  logic                  timer_running_r, timer_running_nxt;
  logic [INTERVAL_W-1:0] timer_rem_r, timer_rem_nxt;
  logic [1:0]            active_r, active_nxt;
  logic [PTIME_W-1:0]    ptime_r   [2];
  logic [PTIME_W-1:0]    ptime_nxt [2];

  // Input register
  logic       s1_valid_r;
  logic [1:0] s1_mode_r;
  logic       s1_sel_r;
  logic       s1_main_lvl_r;
  logic       s1_mirr_lvl_r;

  // Result register
  logic               out_valid_r;
  ev_t                ev_main_r, ev_main_nxt;
  ev_t                ev_mirr_r, ev_mirr_nxt;
  logic               pressed_r, pressed_nxt;
  logic [PTIME_W-1:0] otime_r, otime_nxt;

  logic out_load;
  logic adv;
  logic in_take;

  assign out_load = !out_valid_r || !out_stall;
  assign adv      = s1_valid_r && out_load;
  assign in_stall = s1_valid_r && !out_load;
  assign in_take  = in_valid && !in_stall;

  // Per-word update
  always_comb begin
    sample_t               smp_main;
    sample_t               smp_mirr;
    logic [INTERVAL_W-1:0] rem_dec;
    timer_running_nxt = timer_running_r;
    timer_rem_nxt     = timer_rem_r;
    active_nxt        = active_r;
    ptime_nxt[0]      = ptime_r[0];
    ptime_nxt[1]      = ptime_r[1];
    ev_main_nxt       = EV_NONE;
    ev_mirr_nxt       = EV_NONE;
    rem_dec           = timer_rem_r - 1'b1;
    smp_main = sample_one(active_r[0], s1_main_lvl_r == main_lvl_cfg_r, ptime_r[0],
                          interval_r);
    smp_mirr = sample_one(active_r[1], s1_mirr_lvl_r == mirror_lvl_cfg_r, ptime_r[1],
                          interval_r);
    case (s1_mode_r)
      MODE_TICK: begin
        // interval 0 leaves a running timer parked at zero
        if (timer_running_r && (timer_rem_r != '0)) begin
          timer_rem_nxt = rem_dec;
          if (rem_dec == '0) begin
            timer_rem_nxt = interval_r;
            active_nxt[0] = smp_main.active;
            ptime_nxt[0]  = smp_main.ptime;
            ev_main_nxt   = smp_main.ev;
            if (mirror_en_r) begin
              active_nxt[1] = smp_mirr.active;
              ptime_nxt[1]  = smp_mirr.ptime;
              ev_mirr_nxt   = smp_mirr.ev;
            end
            if (!active_nxt[0] && !active_nxt[1]) begin
              timer_running_nxt = 1'b0;
              timer_rem_nxt     = '0;
            end
          end
        end
      end
      MODE_EDGE: begin
        // edge on an active button is ignored
        if (!active_r[s1_sel_r] && (!s1_sel_r || mirror_en_r)) begin
          ptime_nxt[s1_sel_r]  = '0;
          active_nxt[s1_sel_r] = 1'b1;
          if (!timer_running_r) begin
            timer_running_nxt = 1'b1;
            timer_rem_nxt     = interval_r;
          end
        end
      end
      MODE_CLEAR: begin
        ptime_nxt[s1_sel_r] = '0;
      end
      default: begin
      end
    endcase

    // status after the update; main view merges in the mirror when it is enabled
    pressed_nxt = active_nxt[s1_sel_r];
    otime_nxt   = ptime_nxt[s1_sel_r];
    if (!s1_sel_r && mirror_en_r) begin
      pressed_nxt = pressed_nxt || active_nxt[1];
      if (ptime_nxt[1] > otime_nxt) begin
        otime_nxt = ptime_nxt[1];
      end
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
      timer_running_r  <= 1'b0;
      timer_rem_r      <= '0;
      active_r         <= '0;
      ptime_r[0]       <= '0;
      ptime_r[1]       <= '0;
      interval_r       <= INTERVAL_W'(5);
      main_lvl_cfg_r   <= 1'b0;
      mirror_en_r      <= 1'b0;
      mirror_lvl_cfg_r <= 1'b1;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= s1_valid_r;
      end
      if (adv) begin
        timer_running_r <= timer_running_nxt;
        timer_rem_r     <= timer_rem_nxt;
        active_r        <= active_nxt;
        ptime_r[0]      <= ptime_nxt[0];
        ptime_r[1]      <= ptime_nxt[1];
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_INTERVAL:     interval_r       <= cfg_data[INTERVAL_W-1:0];
          CFG_MAIN_LEVEL:   main_lvl_cfg_r   <= cfg_data[0];
          CFG_MIRROR_EN: begin
            mirror_en_r <= cfg_data[0];
            // dropping the mirror also drops its active flag
            if (!cfg_data[0]) begin
              active_r[1] <= 1'b0;
            end
          end
          CFG_MIRROR_LEVEL: mirror_lvl_cfg_r <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_mode_r     <= in_mode;
      s1_sel_r      <= in_button_index;
      s1_main_lvl_r <= in_main_level;
      s1_mirr_lvl_r <= in_mirror_level;
    end
    if (adv) begin
      ev_main_r <= ev_main_nxt;
      ev_mirr_r <= ev_mirr_nxt;
      pressed_r <= pressed_nxt;
      otime_r   <= otime_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_main_event   = ev_main_r;
  assign out_mirror_event = ev_mirr_r;
  assign out_is_pressed   = pressed_r;
  assign out_pressed_time = otime_r;

  `ASSERT_IMPLIES(a_timer_stop_zero, !timer_running_r, timer_rem_r == '0, "stopped timer not zero")
  `ASSERT_IMPLIES(a_press_active, out_valid_r && (ev_main_r == EV_PRESS), active_r[0], "press on idle main")
  `ASSERT_IMPLIES(a_release_idle, out_valid_r && (ev_main_r == EV_RELEASE), !active_r[0], "release left main active")
  `ASSERT_ALWAYS(a_stall_only_full, !in_stall || s1_valid_r, "input stalled with empty register")

endmodule
`default_nettype wire

// File: tb/dbdt_checker.sv
// Scoreboard for the dual button debounce timer: predicts and checks every result word.
`timescale 1ns / 1ps
module dbdt_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [1:0]                      in_mode,
  input  logic                            in_button_index,
  input  logic                            in_main_level,
  input  logic                            in_mirror_level,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [1:0]                      out_main_event,
  input  logic [1:0]                      out_mirror_event,
  input  logic                            out_is_pressed,
  input  logic [dbdt_pkg::PTIME_W-1:0]    out_pressed_time,
  input  logic                            cfg_we,
  input  logic [dbdt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dbdt_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              pending
);
  import dbdt_pkg::*;

  typedef struct packed {
    ev_t                main_ev;
    ev_t                mirror_ev;
    logic               pressed;
    logic [PTIME_W-1:0] ptime;
  } report_t;

  // Register copies
  logic [INTERVAL_W-1:0] interval;
  logic                  main_lvl;
  logic                  mirror_en;
  logic                  mirror_lvl;

  // Block state copies
  logic                  tmr_running;
  logic [INTERVAL_W-1:0] tmr_left;
  logic                  btn_active [2];
  logic [PTIME_W-1:0]    btn_time [2];

  report_t expected_reports [$];
  report_t want;

  function automatic ev_t sample_button(input int b, input logic at_level);
    logic [17:0] sum;
    logic        first;
    if (!btn_active[b]) return EV_NONE;
    if (!at_level) begin
      btn_active[b] = 1'b0;
      btn_time[b]   = '0;
      return EV_RELEASE;
    end
    // first sample of a press earns two intervals
    first = (btn_time[b] == '0);
    sum = {2'b00, btn_time[b]} + (first ? {7'd0, interval, 1'b0} : {8'd0, interval});
    btn_time[b] = (sum > 18'd65535) ? 16'hFFFF : sum[15:0];
    return first ? EV_PRESS : EV_NONE;
  endfunction

  function automatic report_t predict_report(input logic [1:0] mode, input logic sel,
                                             input logic ml, input logic rl);
    report_t r;
    r.main_ev   = EV_NONE;
    r.mirror_ev = EV_NONE;
    case (mode)
      MODE_TICK: begin
        if (tmr_running && tmr_left != '0) begin
          tmr_left = tmr_left - 1'b1;
          if (tmr_left == '0) begin
            tmr_left  = interval;
            r.main_ev = sample_button(0, ml == main_lvl);
            if (mirror_en) r.mirror_ev = sample_button(1, rl == mirror_lvl);
            if (!btn_active[0] && !btn_active[1]) begin
              tmr_running = 1'b0;
              tmr_left    = '0;
            end
          end
        end
      end
      MODE_EDGE: begin
        if (!btn_active[sel] && (sel == 1'b0 || mirror_en)) begin
          btn_time[sel]   = '0;
          btn_active[sel] = 1'b1;
          if (!tmr_running) begin
            tmr_running = 1'b1;
            tmr_left    = interval;
          end
        end
      end
      MODE_CLEAR: btn_time[sel] = '0;
      default: ;
    endcase
    r.pressed = btn_active[sel];
    r.ptime   = btn_time[sel];
    if (sel == 1'b0 && mirror_en) begin
      r.pressed = r.pressed | btn_active[1];
      if (btn_time[1] > r.ptime) r.ptime = btn_time[1];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      interval      = 10'd5;
      main_lvl      = 1'b0;
      mirror_en     = 1'b0;
      mirror_lvl    = 1'b1;
      tmr_running   = 1'b0;
      tmr_left      = '0;
      btn_active[0] = 1'b0;
      btn_active[1] = 1'b0;
      btn_time[0]   = '0;
      btn_time[1]   = '0;
      expected_reports.delete();
      mismatches <= 0;
      pending    <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_INTERVAL:   interval = cfg_data[INTERVAL_W-1:0];
          CFG_MAIN_LEVEL: main_lvl = cfg_data[0];
          CFG_MIRROR_EN: begin
            mirror_en = cfg_data[0];
            if (!mirror_en) btn_active[1] = 1'b0;
          end
          CFG_MIRROR_LEVEL: mirror_lvl = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result word: main %0d mirror %0d pressed %0b time %0d",
                     out_main_event, out_mirror_event, out_is_pressed, out_pressed_time);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_reports.pop_front();
          if (out_main_event !== want.main_ev || out_mirror_event !== want.mirror_ev ||
              out_is_pressed !== want.pressed || out_pressed_time !== want.ptime) begin
            if (mismatches < 10)
              $display("mismatch: exp ev %0d/%0d prs %0b t %0d, got ev %0d/%0d prs %0b t %0d",
                       want.main_ev, want.mirror_ev, want.pressed, want.ptime,
                       out_main_event, out_mirror_event, out_is_pressed, out_pressed_time);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_reports.push_back(predict_report(in_mode, in_button_index,
                                                  in_main_level, in_mirror_level));
      pending <= expected_reports.size();
    end
  end

endmodule

// File: tb/testbench.sv
// Top of the debounce timer testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module testbench;
  import dbdt_pkg::*;

  // mode code the block leaves unused; must change nothing
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // cycles with no word moving on either channel before we give up
  localparam int QUIET_LIMIT = 5000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            in_mode = MODE_TICK;
  logic                  in_button_index = 1'b0;
  logic                  in_main_level = 1'b0;
  logic                  in_mirror_level = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            out_main_event;
  logic [1:0]            out_mirror_event;
  logic                  out_is_pressed;
  logic [PTIME_W-1:0]    out_pressed_time;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_INTERVAL;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int mismatches;
  int pending;

  // sender gap and receiver stall odds, in percent
  int gap_pct = 0;
  int stall_pct = 0;

  // register values as last written, used to shape presses
  int   cur_iv = 5;
  logic cur_ml = 1'b0;
  logic cur_rl = 1'b1;

  // modeled pin levels of both buttons
  logic main_pin = 1'b1;
  logic mirror_pin = 1'b0;

  int quiet_cycles = 0;

  always #2 clk = ~clk;

  dual_button_debounce_timer_unit u_dut (.*);

  dbdt_checker u_checker (.*);

  // receiver side: random stall, redrawn every cycle
  always @(posedge clk)
    out_stall <= ($urandom_range(0, 99) < stall_pct);

  // watchdog: a hang shows as a long run of cycles where no word moves
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Offer one word and hold it until taken. Valid drops only for the random
  // gaps before a word, so words sent with no gap keep it high without a glitch.
  task automatic put_word(input logic [1:0] mode, input logic sel,
                          input logic ml, input logic rl);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= mode;
    in_button_index <= sel;
    in_main_level   <= ml;
    in_mirror_level <= rl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop sending and wait until every result word is back, then idle for the
  // extra time the caller asks for so the block is truly quiet.
  task automatic drain(input int extra);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (extra) @(posedge clk);
  endtask

  // Writes all four registers back to back; only call when drained.
  task automatic set_regs(input int iv, input logic ml, input logic me, input logic rl);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_INTERVAL;
    cfg_data  <= CFG_DATA_W'(iv);
    @(posedge clk);
    cfg_index <= CFG_MAIN_LEVEL;
    cfg_data  <= CFG_DATA_W'(ml);
    @(posedge clk);
    cfg_index <= CFG_MIRROR_EN;
    cfg_data  <= CFG_DATA_W'(me);
    @(posedge clk);
    cfg_index <= CFG_MIRROR_LEVEL;
    cfg_data  <= CFG_DATA_W'(rl);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_iv = iv;
    cur_ml = ml;
    cur_rl = rl;
  endtask

  // Random traffic built mostly from real presses: a pin goes active with an
  // edge word, ticks run while it is held, then it lets go. Noise edges,
  // clears, unused modes and the odd missing edge are mixed in.
  task automatic random_run(input int count);
    int   done;
    int   pick;
    logic sel;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      sel  = 1'($urandom_range(0, 1));
      // now and then let everything settle before going on
      if ($urandom_range(0, 49) == 0) drain(0);
      if (pick < 8) begin
        put_word(MODE_EDGE, sel, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else if (pick < 13) begin
        put_word(MODE_CLEAR, sel, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else if (pick < 15) begin
        put_word(MODE_UNUSED, sel, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        // pins change slowly against the interval so presses last a few samples
        if ($urandom_range(0, 3 * cur_iv) == 0) begin
          main_pin = ~main_pin;
          if (main_pin == cur_ml && $urandom_range(0, 9) != 0) begin
            put_word(MODE_EDGE, 1'b0, main_pin, mirror_pin);
            done++;
          end
        end
        if ($urandom_range(0, 3 * cur_iv) == 0) begin
          mirror_pin = ~mirror_pin;
          if (mirror_pin == cur_rl && $urandom_range(0, 9) != 0) begin
            put_word(MODE_EDGE, 1'b1, main_pin, mirror_pin);
            done++;
          end
        end
        put_word(MODE_TICK, sel, main_pin, mirror_pin);
      end
      done++;
    end
  endtask

  int iv_tab [6] = '{3, 1, 7, 2, 1, 12};
  logic ml_tab [6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
  logic me_tab [6] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
  logic rl_tab [6] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part ---
    // reset settings: status only, a tick with the timer stopped, mirror edge ignored
    put_word(MODE_UNUSED, 1'b1, 1'b1, 1'b1);
    put_word(MODE_TICK, 1'b0, 1'b1, 1'b0);
    put_word(MODE_EDGE, 1'b1, 1'b1, 1'b1);
    drain(3);
    set_regs(2, 1'b0, 1'b1, 1'b1);
    put_word(MODE_EDGE, 1'b0, 1'b0, 1'b1);   // main goes active, timer starts
    put_word(MODE_EDGE, 1'b0, 1'b0, 1'b1);   // edge on an active button: ignored
    put_word(MODE_EDGE, 1'b1, 1'b0, 1'b1);   // mirror goes active
    put_word(MODE_TICK, 1'b0, 1'b0, 1'b1);
    put_word(MODE_TICK, 1'b0, 1'b0, 1'b1);   // first sample: both report press
    put_word(MODE_CLEAR, 1'b0, 1'b0, 1'b1);  // clear while held
    put_word(MODE_TICK, 1'b1, 1'b0, 1'b1);
    put_word(MODE_TICK, 1'b0, 1'b0, 1'b1);   // main reports press again
    put_word(MODE_TICK, 1'b0, 1'b1, 1'b1);
    put_word(MODE_TICK, 1'b1, 1'b1, 1'b1);   // main let go: release
    put_word(MODE_TICK, 1'b0, 1'b1, 1'b0);
    put_word(MODE_TICK, 1'b0, 1'b1, 1'b0);   // mirror release, timer stops
    put_word(MODE_TICK, 1'b0, 1'b0, 1'b1);   // stopped timer: nothing
    put_word(MODE_EDGE, 1'b1, 1'b0, 1'b1);   // mirror active again
    drain(3);
    // dropping the mirror clears its active flag; timer still mid count
    set_regs(1, 1'b1, 1'b0, 1'b0);
    put_word(MODE_EDGE, 1'b1, 1'b1, 1'b0);   // mirror disabled: ignored
    put_word(MODE_TICK, 1'b1, 1'b1, 1'b0);
    put_word(MODE_EDGE, 1'b0, 1'b1, 1'b0);
    put_word(MODE_TICK, 1'b0, 1'b1, 1'b0);
    put_word(MODE_TICK, 1'b0, 1'b1, 1'b1);
    put_word(MODE_TICK, 1'b0, 1'b0, 1'b1);

    // --- random part: receiver-heavy stalls, then sender-heavy gaps, then none ---
    for (int ph = 0; ph < 6; ph++) begin
      drain(3);
      gap_pct = (ph < 2) ? 11 : (ph < 4) ? 73 : 0;
      stall_pct <= (ph < 2) ? 73 : (ph < 4) ? 11 : 0;
      set_regs(iv_tab[ph], ml_tab[ph], me_tab[ph], rl_tab[ph]);
      random_run(100);
    end

    // --- long press on both buttons over a few samples, then both let go ---
    drain(3);
    set_regs(20, 1'b0, 1'b1, 1'b1);
    put_word(MODE_EDGE, 1'b0, 1'b0, 1'b1);
    put_word(MODE_EDGE, 1'b1, 1'b0, 1'b1);
    repeat (50) put_word(MODE_TICK, 1'($urandom_range(0, 1)), 1'b0, 1'b1);
    repeat (25) put_word(MODE_TICK, 1'($urandom_range(0, 1)), 1'b1, 1'b0);

    // --- zero interval, last because the timer never moves again ---
    drain(3);
    set_regs(3, 1'b0, 1'b1, 1'b1);
    put_word(MODE_EDGE, 1'b0, 1'b0, 1'b0);
    drain(3);
    set_regs(0, 1'b0, 1'b1, 1'b1);
    // countdown ends, reloads zero: press with a gain of nothing, then stuck
    repeat (5) put_word(MODE_TICK, 1'b0, 1'b0, 1'b0);
    put_word(MODE_EDGE, 1'b1, 1'b0, 1'b1);
    put_word(MODE_CLEAR, 1'b0, 1'b0, 1'b1);
    put_word(MODE_UNUSED, 1'b0, 1'b1, 1'b0);
    repeat (4) put_word(MODE_TICK, 1'($urandom_range(0, 1)), 1'b1, 1'b0);

    drain(8);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: dual_button_debounce_timer_unit.f
+incdir+rtl
rtl/dbdt_pkg.sv
rtl/dual_button_debounce_timer_unit.sv
tb/dbdt_checker.sv
tb/testbench.sv
